// ----- design/bitmap_block_allocator_defines.svh -----
// Assertion helpers for the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk and masked during reset.
`define BBA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and masked during reset.
`define BBA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bba_pkg.sv -----
`timescale 1ns / 1ps

package bba_pkg;

	// Bitmap geometry
	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int ADDR_W     = $clog2(NUM_WORDS);
	localparam int LIMIT_W    = BLK_W + 1;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_OUT_OF_BLOCKS = 2'd1,
		ST_DOUBLE_FREE   = 2'd2,
		ST_OUT_OF_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE
	} state_t;

	// Port request into the bitmap RAM
	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [ADDR_W-1:0]    wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} ram_req_t;

	// Index of the lowest set bit; zero when none is set
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] bits);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (bits[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- design/bba_bitmap_ram.sv -----
`timescale 1ns / 1ps

module bba_bitmap_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::ram_req_t             req,
	output logic [bba_pkg::WORD_BITS-1:0] rd_word
);

	logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::NUM_WORDS];
	logic [bba_pkg::NUM_WORDS-1:0] valid_q;
	logic [bba_pkg::WORD_BITS-1:0] rd_data_s1;
	logic                          rd_vld_s1;

	// Storage array, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.rd_addr];
		end
	end

	// Per-word written flags; an unwritten word reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_word = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

// ----- design/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps

// Bitmap first-fit block allocator.
// Requests: drive op and block_number with start; a request is taken on a clock
// edge where start is high and busy is low. op allocate returns the lowest free
// block below the configured count and marks it used; op free clears a block.
// Results: done pulses for one cycle with granted_block and status. The
// receiver cannot stall, so results are never held back or repeated.
// Sequencing: an allocation reads one bitmap word per cycle from the word RAM,
// from word 0 up to the word k that holds the free block (k from 0 to 63).
// A free reads its word, then writes it back with the bit cleared unless it
// is a double free. For both, done follows the last busy cycle. A free
// out of range, or an allocation with a block count of zero, answers the cycle
// after the request without raising busy.
// Configuration: cfg_write loads cfg_data into the block count; write only
// while idle. Counts above 4096 act as 4096.
// Reset: bitmap reads as all free right away (per-word written flags), block
// count returns to 4096, no pending result.

module bitmap_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [bba_pkg::BLK_W-1:0]   block_number,
	output logic                        done,
	output logic [bba_pkg::BLK_W-1:0]   granted_block,
	output logic [1:0]                  status,
	input  logic                        cfg_write,
	input  logic [bba_pkg::LIMIT_W-1:0] cfg_data
);

	bba_pkg::state_t                state_q, state_d;
	logic [bba_pkg::LIMIT_W-1:0]    total_q;
	logic [bba_pkg::LIMIT_W-1:0]    limit;
	logic [bba_pkg::ADDR_W-1:0]     scan_w_q, scan_w_d;
	logic [bba_pkg::BLK_W-1:0]      blk_q, blk_d;
	logic                           done_q;
	logic [bba_pkg::BLK_W-1:0]      grant_q;
	bba_pkg::status_t               status_q;
	logic                           rsp_load;
	logic [bba_pkg::BLK_W-1:0]      rsp_grant;
	bba_pkg::status_t               rsp_status;
	bba_pkg::ram_req_t              ram_req;
	logic [bba_pkg::WORD_BITS-1:0]  rd_word;
	logic [bba_pkg::WORD_BITS-1:0]  range_mask;
	logic [bba_pkg::WORD_BITS-1:0]  free_bits;
	logic [bba_pkg::BIT_W-1:0]      free_idx;
	logic [bba_pkg::ADDR_W:0]       next_w;
	logic                           last_word;
	logic                           accept;

	bba_bitmap_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_word (rd_word)
	);

	assign accept = start && !busy;
	assign busy   = (state_q != bba_pkg::S_IDLE);

	// Effective block count
	assign limit = (total_q > bba_pkg::LIMIT_W'(bba_pkg::NUM_BLOCKS))
		? bba_pkg::LIMIT_W'(bba_pkg::NUM_BLOCKS) : total_q;

	// Bits of the scanned word that lie below the block count
	always_comb begin
		if (limit[bba_pkg::LIMIT_W-1:bba_pkg::BIT_W] > {1'b0, scan_w_q}) begin
			range_mask = '1;
		end else begin
			range_mask = (bba_pkg::WORD_BITS'(1) << limit[bba_pkg::BIT_W-1:0])
				- bba_pkg::WORD_BITS'(1);
		end
	end

	assign free_bits = ~rd_word & range_mask;
	assign free_idx  = bba_pkg::lowest_set(free_bits);
	assign next_w    = {1'b0, scan_w_q} + (bba_pkg::ADDR_W + 1)'(1);
	assign last_word = ({next_w, {bba_pkg::BIT_W{1'b0}}} >= limit);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
			total_q <= bba_pkg::LIMIT_W'(bba_pkg::NUM_BLOCKS);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= rsp_load;
			if (cfg_write) begin
				total_q <= cfg_data;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		scan_w_q <= scan_w_d;
		blk_q    <= blk_d;
		if (rsp_load) begin
			grant_q  <= rsp_grant;
			status_q <= rsp_status;
		end
	end

	// Sequencer: next state, RAM port and response
	always_comb begin
		state_d    = state_q;
		scan_w_d   = scan_w_q;
		blk_d      = blk_q;
		rsp_load   = 1'b0;
		rsp_grant  = '0;
		rsp_status = bba_pkg::ST_OK;
		ram_req    = '0;
		case (state_q)
			bba_pkg::S_IDLE: begin
				if (accept) begin
					blk_d = block_number;
					if (op == bba_pkg::OP_ALLOC) begin
						if (limit == '0) begin
							rsp_load   = 1'b1;
							rsp_status = bba_pkg::ST_OUT_OF_BLOCKS;
						end else begin
							ram_req.rd_en   = 1'b1;
							ram_req.rd_addr = '0;
							scan_w_d        = '0;
							state_d         = bba_pkg::S_ALLOC;
						end
					end else begin
						if ({1'b0, block_number} >= limit) begin
							rsp_load   = 1'b1;
							rsp_status = bba_pkg::ST_OUT_OF_RANGE;
						end else begin
							ram_req.rd_en   = 1'b1;
							ram_req.rd_addr = block_number[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
							state_d         = bba_pkg::S_FREE;
						end
					end
				end
			end
			bba_pkg::S_ALLOC: begin
				if (|free_bits) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = scan_w_q;
					ram_req.wr_data = rd_word | (bba_pkg::WORD_BITS'(1) << free_idx);
					rsp_load        = 1'b1;
					rsp_grant       = {scan_w_q, free_idx};
					rsp_status      = bba_pkg::ST_OK;
					state_d         = bba_pkg::S_IDLE;
				end else if (last_word) begin
					rsp_load   = 1'b1;
					rsp_status = bba_pkg::ST_OUT_OF_BLOCKS;
					state_d    = bba_pkg::S_IDLE;
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = next_w[bba_pkg::ADDR_W-1:0];
					scan_w_d        = next_w[bba_pkg::ADDR_W-1:0];
				end
			end
			bba_pkg::S_FREE: begin
				rsp_load = 1'b1;
				state_d  = bba_pkg::S_IDLE;
				if (!rd_word[blk_q[bba_pkg::BIT_W-1:0]]) begin
					rsp_status = bba_pkg::ST_DOUBLE_FREE;
				end else begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = blk_q[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
					ram_req.wr_data = rd_word
						& ~(bba_pkg::WORD_BITS'(1) << blk_q[bba_pkg::BIT_W-1:0]);
					rsp_status = bba_pkg::ST_OK;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	assign done          = done_q;
	assign granted_block = grant_q;
	assign status        = status_q;

`include "bitmap_block_allocator_defines.svh"

	`BBA_ASSERT_NOW(a_done_idle, done_q, state_q == bba_pkg::S_IDLE, "result while busy")
	`BBA_ASSERT_NOW(a_scan_in_range, state_q == bba_pkg::S_ALLOC, {scan_w_q, {bba_pkg::BIT_W{1'b0}}} < limit, "scan past block count")
	`BBA_ASSERT_NOW(a_grant_in_range, done_q && grant_q != '0, {1'b0, grant_q} < limit, "grant beyond block count")
	`BBA_ASSERT_NEXT(a_write_ends, ram_req.wr_en, state_q == bba_pkg::S_IDLE && done_q, "write-back without result")

endmodule
